// ===== design/pff_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pff_pkg
// Shared types and constants of the Pareto frontier filter.
// ----------------------------------------------------------------------------
package pff_pkg;

    localparam int DATA_W          = 32;
    localparam int ENTRY_W         = 6;
    localparam int MAX_RECORDS_DEF = 32;
    localparam int IN_TDATA_W      = 128;
    localparam int OUT_TDATA_W     = 136;

    typedef struct packed {
        logic [DATA_W-1:0] transactions;
        logic [DATA_W-1:0] misses;
        logic [DATA_W-1:0] accesses;
        logic [DATA_W-1:0] capacity;
    } rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOM,
        ST_DRAIN,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_SELECT
    } state_t;

endpackage

// ===== design/pareto_frontier_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pareto_frontier_filter_top
// Loads cache experiment records and emits the non-dominated ones in
// ascending capacity order.
// Records load one per cycle. After the final record, the dominance pass feeds
// one pair per cycle through the compare pipeline, then each frontier item
// takes one store scan and one more scan ends the set; no new record is taken
// until the last frontier item is handed to the output register.
// Reset clears all control state; the record store is not cleared.
// ----------------------------------------------------------------------------
module pareto_frontier_filter_top #(
    parameter int MAX_RECORDS = pff_pkg::MAX_RECORDS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // capacity, access_count, miss_count, transaction_count
    input  logic [pff_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // entry_index, out_capacity, out_accesses, out_misses, out_transactions
    output logic [pff_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // overflow
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast
);
    import pff_pkg::*;

    localparam int IW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    rec_t          wr_data;
    logic          job_valid, job_ready, job_dropped, done;
    logic [CW-1:0] job_count;

    pff_front #(.MAX_RECORDS(MAX_RECORDS)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .job_valid     (job_valid),
        .job_ready     (job_ready),
        .job_count     (job_count),
        .job_dropped   (job_dropped),
        .done          (done)
    );

    pff_back #(.MAX_RECORDS(MAX_RECORDS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .job_valid     (job_valid),
        .job_ready     (job_ready),
        .job_count     (job_count),
        .job_dropped   (job_dropped),
        .done          (done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== design/pff_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pff_front
// Accepts record items, writes those that fit to the store and hands a job to
// the back end when the final record of a set arrives.
// ----------------------------------------------------------------------------
module pff_front #(
    parameter int MAX_RECORDS = pff_pkg::MAX_RECORDS_DEF,
    localparam int IW = $clog2(MAX_RECORDS),
    localparam int CW = $clog2(MAX_RECORDS + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // capacity, access_count, miss_count, transaction_count
    input  logic [pff_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            wr_en,
    output logic [IW-1:0]                   wr_addr,
    output pff_pkg::rec_t                   wr_data,
    output logic                            job_valid,
    input  logic                            job_ready,
    output logic [CW-1:0]                   job_count,
    output logic                            job_dropped,
    input  logic                            done
);
    import pff_pkg::*;

    logic [CW-1:0] count_reg;
    logic          dropped_reg;
    logic          busy_reg;
    logic          job_valid_reg;
    logic [CW-1:0] job_count_reg;
    logic          job_dropped_reg;
    logic          accept;
    logic          room;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign room          = count_reg < CW'(MAX_RECORDS);
    assign s_axis_tready = !busy_reg;
    assign wr_en         = accept && room;
    assign wr_addr       = count_reg[IW-1:0];
    assign wr_data       = rec_t'(s_axis_tdata);
    assign job_valid     = job_valid_reg;
    assign job_count     = job_count_reg;
    assign job_dropped   = job_dropped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            busy_reg      <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_valid_reg && job_ready)
            begin
                job_valid_reg <= 1'b0;
            end
            if (done)
            begin
                busy_reg <= 1'b0;
            end
            if (accept)
            begin
                if (s_axis_tlast)
                begin
                    count_reg     <= '0;
                    dropped_reg   <= 1'b0;
                    busy_reg      <= 1'b1;
                    job_valid_reg <= 1'b1;
                end
                else if (room)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else
                begin
                    dropped_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_axis_tlast)
        begin
            job_count_reg   <= room ? count_reg + CW'(1) : count_reg;
            job_dropped_reg <= dropped_reg || !room;
        end
    end

endmodule

// ===== design/pff_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pff_back
// Holds the record store, marks dominated records with a pipelined pairwise
// compare and emits the frontier in ascending capacity by repeated scans.
// ----------------------------------------------------------------------------
module pff_back #(
    parameter int MAX_RECORDS = pff_pkg::MAX_RECORDS_DEF,
    localparam int IW = $clog2(MAX_RECORDS),
    localparam int CW = $clog2(MAX_RECORDS + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [IW-1:0]                   wr_addr,
    input  pff_pkg::rec_t                   wr_data,
    input  logic                            job_valid,
    output logic                            job_ready,
    input  logic [CW-1:0]                   job_count,
    input  logic                            job_dropped,
    output logic                            done,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // entry_index, out_capacity, out_accesses, out_misses, out_transactions
    output logic [pff_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // overflow
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast
);
    import pff_pkg::*;

    rec_t mem [MAX_RECORDS];

    state_t            state_reg, state_next;
    logic [CW-1:0]     n_reg;
    logic              ovf_reg;
    logic [IW-1:0]     di_reg, dj_reg, k_reg;
    logic [IW-1:0]     addr_a, addr_b;
    rec_t              rd_a_reg, rd_b_reg;
    logic              s1_v_reg, s2_v_reg, scan_v_reg;
    logic [IW-1:0]     s1_i_reg, s1_j_reg, s2_i_reg, s2_j_reg, scan_k_reg;
    logic [63:0]       pm_l_reg, pm_r_reg, pt_l_reg, pt_r_reg;
    logic              cap_le_reg, cap_lt_reg;
    logic [MAX_RECORDS-1:0] dom_reg;
    logic              best_valid_reg, pend_valid_reg;
    logic [IW-1:0]     best_idx_reg, pend_idx_reg;
    rec_t              best_rec_reg, pend_rec_reg;
    logic              m_valid_reg, m_ovf_reg, m_last_reg;
    logic [IW-1:0]     m_idx_reg;
    rec_t              m_rec_reg;

    logic [DATA_W-1:0] acc_j, acc_i, mis_j, mis_i, trn_j, trn_i;
    logic              last_pair, last_k, out_free, load_out, take_best, start;
    logic              dom_hit, cand, beats;

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign last_pair = (CW'(di_reg) == n_reg - CW'(1)) && (CW'(dj_reg) == n_reg - CW'(1));
    assign last_k    = CW'(k_reg) == n_reg - CW'(1);
    assign job_ready = state_reg == ST_IDLE;
    assign start     = job_valid && job_ready;
    assign addr_a    = (state_reg == ST_SCAN) ? k_reg : dj_reg;
    assign addr_b    = di_reg;

    assign acc_j = (rd_a_reg.accesses != '0) ? rd_a_reg.accesses : DATA_W'(1);
    assign acc_i = (rd_b_reg.accesses != '0) ? rd_b_reg.accesses : DATA_W'(1);
    assign mis_j = (rd_a_reg.accesses != '0) ? rd_a_reg.misses : '0;
    assign mis_i = (rd_b_reg.accesses != '0) ? rd_b_reg.misses : '0;
    assign trn_j = (rd_a_reg.accesses != '0) ? rd_a_reg.transactions : '0;
    assign trn_i = (rd_b_reg.accesses != '0) ? rd_b_reg.transactions : '0;

    assign dom_hit = s2_v_reg && (s2_i_reg != s2_j_reg)
                     && cap_le_reg && (pm_l_reg <= pm_r_reg) && (pt_l_reg <= pt_r_reg)
                     && (cap_lt_reg || (pm_l_reg < pm_r_reg) || (pt_l_reg < pt_r_reg));

    assign cand  = scan_v_reg && !dom_reg[scan_k_reg]
                   && (!pend_valid_reg
                       || (rd_a_reg.capacity > pend_rec_reg.capacity)
                       || ((rd_a_reg.capacity == pend_rec_reg.capacity)
                           && (scan_k_reg > pend_idx_reg)));
    assign beats = !best_valid_reg || (rd_a_reg.capacity < best_rec_reg.capacity);

    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        take_best  = 1'b0;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = ST_DOM;
                end
            end
            ST_DOM:
            begin
                if (last_pair)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_v_reg && !s2_v_reg)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_k)
                begin
                    state_next = ST_SCAN_WAIT;
                end
            end
            ST_SCAN_WAIT:
            begin
                state_next = ST_SELECT;
            end
            ST_SELECT:
            begin
                if (best_valid_reg)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        take_best  = 1'b1;
                        load_out   = pend_valid_reg;
                        state_next = ST_SCAN;
                    end
                end
                else if (out_free)
                begin
                    load_out   = 1'b1;
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            s1_v_reg       <= 1'b0;
            s2_v_reg       <= 1'b0;
            scan_v_reg     <= 1'b0;
            best_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            di_reg         <= '0;
            dj_reg         <= '0;
            k_reg          <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            s1_v_reg   <= state_reg == ST_DOM;
            s2_v_reg   <= s1_v_reg;
            scan_v_reg <= state_reg == ST_SCAN;
            if (start)
            begin
                di_reg         <= '0;
                dj_reg         <= '0;
                pend_valid_reg <= 1'b0;
            end
            else if (state_reg == ST_DOM)
            begin
                if (CW'(dj_reg) == n_reg - CW'(1))
                begin
                    dj_reg <= '0;
                    di_reg <= di_reg + IW'(1);
                end
                else
                begin
                    dj_reg <= dj_reg + IW'(1);
                end
            end
            if (state_reg == ST_SCAN)
            begin
                k_reg <= k_reg + IW'(1);
            end
            if ((state_reg == ST_DRAIN) || take_best)
            begin
                k_reg          <= '0;
                best_valid_reg <= 1'b0;
            end
            else if (cand && beats)
            begin
                best_valid_reg <= 1'b1;
            end
            if (take_best)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
        s1_i_reg <= di_reg;
        s1_j_reg <= dj_reg;
        s2_i_reg <= s1_i_reg;
        s2_j_reg <= s1_j_reg;
        pm_l_reg <= {32'b0, mis_j} * {32'b0, acc_i};
        pm_r_reg <= {32'b0, mis_i} * {32'b0, acc_j};
        pt_l_reg <= {32'b0, trn_j} * {32'b0, acc_i};
        pt_r_reg <= {32'b0, trn_i} * {32'b0, acc_j};
        cap_le_reg <= rd_a_reg.capacity <= rd_b_reg.capacity;
        cap_lt_reg <= rd_a_reg.capacity < rd_b_reg.capacity;
        scan_k_reg <= k_reg;
        if (start)
        begin
            n_reg   <= job_count;
            ovf_reg <= job_dropped;
            dom_reg <= '0;
        end
        else if (dom_hit)
        begin
            dom_reg[s2_i_reg] <= 1'b1;
        end
        if (cand && beats && !take_best)
        begin
            best_idx_reg <= scan_k_reg;
            best_rec_reg <= rd_a_reg;
        end
        if (take_best)
        begin
            pend_idx_reg <= best_idx_reg;
            pend_rec_reg <= best_rec_reg;
        end
        if (load_out)
        begin
            m_idx_reg  <= pend_idx_reg;
            m_rec_reg  <= pend_rec_reg;
            m_ovf_reg  <= ovf_reg;
            m_last_reg <= !best_valid_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, m_rec_reg.transactions, m_rec_reg.misses,
                            m_rec_reg.accesses, m_rec_reg.capacity, ENTRY_W'(m_idx_reg)};
    assign m_axis_tuser  = m_ovf_reg;
    assign m_axis_tlast  = m_last_reg;

    a_scan_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (!s1_v_reg && !s2_v_reg))
        else $error("scan started before dominance pipeline drained");

    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && job_ready) |-> (job_count != '0))
        else $error("empty job handed to back end");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s2_v_reg && scan_v_reg))
        else $error("dominance compare and scan overlap");

    a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && !best_valid_reg) |=> (state_reg == ST_IDLE && m_axis_tlast))
        else $error("final item not tied to end of job");

endmodule
